// ----- rtl/bfme_pkg.sv -----
package bfme_pkg;

  // Input item kinds carried on the slave tuser.
  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_RANGE  = 2'd1,
    KIND_FILTER = 2'd2
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_RADIUS = 3'd2,
    REG_SW0    = 3'd3,
    REG_SW1    = 3'd4,
    REG_SW2    = 3'd5,
    REG_SW3    = 3'd6,
    REG_SHIFT  = 3'd7
  } reg_e;

  // Controller states, one-hot.
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CENTRE = 7'b0000010,
    ST_CWAIT  = 7'b0000100,
    ST_TAPS   = 7'b0001000,
    ST_DRAIN  = 7'b0010000,
    ST_DIV    = 7'b0100000,
    ST_LOAD   = 7'b1000000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_pixel;
    logic wr_range;
    logic latch_req;
    logic latch_centre;
    logic clear_acc;
    logic issue_tap;
    logic div_start;
    logic div_step;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pipe_busy;
    logic div_last;
    logic out_full;
  } sts_t;

  localparam int unsigned DIV_STEPS = 16;

endpackage

// ----- rtl/bilateral_filter_mirror_edges_top.sv -----
// Channel    Direction  Handshake                        Payload
// s_axis     in         s_axis_tvalid / s_axis_tready    tdata, tuser (kind)
// m_axis     out        m_axis_tvalid / m_axis_tready    tdata, tuser (zero_weight)
// cfg        in         cfg_valid_i / cfg_ready_o        cfg_index_i, cfg_data_i
//
// Pixel and range-table writes are taken while idle and written directly.
// A filter request reads the centre pixel, then issues one tap per cycle through
// the single frame-store read port, drains a four-stage tap pipeline, and runs
// sixteen steps of the bit-serial divider.
// Reset sets control state and the configuration registers; both stores hold nothing until written.
// A finished result waits in the output register; a new item is accepted meanwhile.
module bilateral_filter_mirror_edges_top #(
  parameter int MAX_WIDTH   = 64,
  parameter int MAX_HEIGHT  = 64,
  parameter int MAX_RADIUS  = 3,
  parameter int RANGE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // row[5:0], col[11:6], value[27:12], table_index[35:28]
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // filtered[15:0], out_row[21:16], out_col[27:22]
  output logic [0:0]  m_axis_tuser,  // zero_weight[0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import bfme_pkg::*;

  localparam int RW = $clog2(MAX_RADIUS + 1);
  localparam int DW = RW + 1;

  cmd_t cmd;
  sts_t sts;
  logic [RW-1:0]        radius;
  logic signed [DW-1:0] di, dj;
  logic [15:0]          filtered;
  logic [5:0]           out_row, out_col;
  logic                 zero_weight;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  bfme_ctrl #(
    .RW (RW),
    .DW (DW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_kind_i  (s_axis_tuser),
    .radius_i   (radius),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .di_o       (di),
    .dj_o       (dj)
  );

  bfme_datapath #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_RADIUS  (MAX_RADIUS),
    .RANGE_DEPTH (RANGE_DEPTH),
    .RW          (RW),
    .DW          (DW)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_row_i         (s_axis_tdata[5:0]),
    .in_col_i         (s_axis_tdata[11:6]),
    .in_value_i       (s_axis_tdata[27:12]),
    .in_table_index_i (s_axis_tdata[35:28]),
    .cmd_i            (cmd),
    .di_i             (di),
    .dj_i             (dj),
    .radius_o         (radius),
    .sts_o            (sts),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .filtered_o       (filtered),
    .out_row_o        (out_row),
    .out_col_o        (out_col),
    .zero_weight_o    (zero_weight)
  );

  assign m_axis_tdata = {4'd0, out_col, out_row, filtered};
  assign m_axis_tuser = zero_weight;

endmodule

// ----- rtl/bfme_datapath.sv -----
module bfme_datapath #(
  parameter int MAX_WIDTH   = 64,
  parameter int MAX_HEIGHT  = 64,
  parameter int MAX_RADIUS  = 3,
  parameter int RANGE_DEPTH = 256,
  parameter int RW          = 2,
  parameter int DW          = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  input  logic [5:0]           in_row_i,
  input  logic [5:0]           in_col_i,
  input  logic [15:0]          in_value_i,
  input  logic [7:0]           in_table_index_i,
  input  bfme_pkg::cmd_t       cmd_i,
  input  logic signed [DW-1:0] di_i,
  input  logic signed [DW-1:0] dj_i,
  output logic [RW-1:0]        radius_o,
  output bfme_pkg::sts_t       sts_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [15:0]          filtered_o,
  output logic [5:0]           out_row_o,
  output logic [5:0]           out_col_o,
  output logic                 zero_weight_o
);
  import bfme_pkg::*;

  localparam int MAX_D = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int IW    = (($clog2(MAX_D) > 6) ? $clog2(MAX_D) : 6) + 3;
  localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int RIW   = $clog2(RANGE_DEPTH);
  localparam int TAPS  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int DEN_W = 32 + $clog2(TAPS);
  localparam int NUM_W = DEN_W + 16;

  // Configuration registers.
  logic [6:0]  width_q, height_q;
  logic [1:0]  radius_q;
  logic [15:0] sw_q [4];
  logic [3:0]  shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 7'd64;
      height_q <= 7'd64;
      radius_q <= 2'd1;
      sw_q[0]  <= 16'hFFFF;
      sw_q[1]  <= 16'd0;
      sw_q[2]  <= 16'd0;
      sw_q[3]  <= 16'd0;
      shift_q  <= 4'd8;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_WIDTH:  width_q  <= cfg_data_i[6:0];
        REG_HEIGHT: height_q <= cfg_data_i[6:0];
        REG_RADIUS: radius_q <= cfg_data_i[1:0];
        REG_SW0:    sw_q[0]  <= cfg_data_i;
        REG_SW1:    sw_q[1]  <= cfg_data_i;
        REG_SW2:    sw_q[2]  <= cfg_data_i;
        REG_SW3:    sw_q[3]  <= cfg_data_i;
        REG_SHIFT:  shift_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Effective frame size and radius after clamping.
  logic signed [IW-1:0] w_eff, h_eff;

  always_comb begin
    if (width_q == 7'd0) begin
      w_eff = IW'(1);
    end else if ($signed(IW'(width_q)) > $signed(IW'(MAX_WIDTH))) begin
      w_eff = IW'(MAX_WIDTH);
    end else begin
      w_eff = $signed(IW'(width_q));
    end
    if (height_q == 7'd0) begin
      h_eff = IW'(1);
    end else if ($signed(IW'(height_q)) > $signed(IW'(MAX_HEIGHT))) begin
      h_eff = IW'(MAX_HEIGHT);
    end else begin
      h_eff = $signed(IW'(height_q));
    end
  end

  assign radius_o = (int'(radius_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_q);

  // Request registers.
  logic [5:0] row_q, col_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      row_q <= in_row_i;
      col_q <= in_col_i;
    end
  end

  // Centre clamped into the frame in use.
  logic signed [IW-1:0] row_s, col_s, cr, cc;

  assign row_s = $signed(IW'(row_q));
  assign col_s = $signed(IW'(col_q));
  assign cr    = (row_s < h_eff) ? row_s : h_eff - IW'(1);
  assign cc    = (col_s < w_eff) ? col_s : w_eff - IW'(1);

  // Reflect an index at the frame edges, then clamp it into range.
  function automatic logic signed [IW-1:0] mirror(input logic signed [IW-1:0] v_in,
                                                  input logic signed [IW-1:0] n);
    logic signed [IW-1:0] v;
    v = v_in;
    if (v < 0) v = -v;
    if (v >= n) v = (n <<< 1) - IW'(1) - v;
    if (v < 0) v = '0;
    if (v >= n) v = n - IW'(1);
    return v;
  endfunction

  logic signed [IW-1:0] vi, vj;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic                 wr_ok;

  assign vi      = mirror(cr + IW'(di_i), h_eff);
  assign vj      = mirror(cc + IW'(dj_i), w_eff);
  assign rd_addr = AW'(int'(vi) * MAX_WIDTH + int'(vj));
  assign wr_addr = AW'(int'(in_row_i) * MAX_WIDTH + int'(in_col_i));
  assign wr_ok   = (int'(in_row_i) < MAX_HEIGHT) && (int'(in_col_i) < MAX_WIDTH);

  // Frame store: one write port, one registered read port.
  logic [15:0] fmem [MAX_WIDTH * MAX_HEIGHT];
  logic [15:0] pix_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_pixel && wr_ok) begin
      fmem[wr_addr] <= in_value_i;
    end
    pix_rd_q <= fmem[rd_addr];
  end

  // Centre pixel is taken from the registered read of the centre address.
  logic [15:0] centre_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_centre) begin
      centre_q <= pix_rd_q;
    end
  end

  // Range index from the absolute difference.
  logic [15:0]    diff, diff_sh;
  logic [RIW-1:0] ridx;
  logic [RIW-1:0] wr_ridx;

  assign diff    = (pix_rd_q > centre_q) ? pix_rd_q - centre_q : centre_q - pix_rd_q;
  assign diff_sh = diff >> shift_q;
  assign ridx    = (int'(diff_sh) > RANGE_DEPTH - 1) ? RIW'(RANGE_DEPTH - 1) : RIW'(diff_sh);
  assign wr_ridx = RIW'(in_table_index_i);

  // Range table: one write port, one registered read port.
  logic [15:0] rmem [RANGE_DEPTH];
  logic [15:0] rng_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_range && (int'(in_table_index_i) < RANGE_DEPTH)) begin
      rmem[wr_ridx] <= in_value_i;
    end
    rng_q <= rmem[ridx];
  end

  // Tap pipeline: read, range lookup and spatial weight, tap weight, product.
  logic        v1_q, v2_q, v3_q, v4_q;
  logic [1:0]  ai1_q, aj1_q;
  logic [15:0] s_q, pix2_q, pix3_q;
  logic [31:0] ss_prod, tw_q, tw4_q;
  logic [47:0] prod_q;
  logic signed [DW-1:0] adi, adj;

  assign adi     = (di_i < 0) ? -di_i : di_i;
  assign adj     = (dj_i < 0) ? -dj_i : dj_i;
  assign ss_prod = sw_q[ai1_q] * sw_q[aj1_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue_tap;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ai1_q  <= adi[1:0];
    aj1_q  <= adj[1:0];
    s_q    <= ss_prod[31:16];
    pix2_q <= pix_rd_q;
    tw_q   <= s_q * rng_q;
    pix3_q <= pix2_q;
    prod_q <= tw_q * pix3_q;
    tw4_q  <= tw_q;
  end

  // Numerator and denominator accumulators.
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_acc) begin
      num_q <= '0;
      den_q <= '0;
    end else if (v4_q) begin
      num_q <= num_q + NUM_W'(prod_q);
      den_q <= den_q + DEN_W'(tw4_q);
    end
  end

  // Restoring divider, one quotient bit per cycle. The weighted mean never
  // exceeds the largest pixel, so sixteen quotient bits are enough.
  logic [NUM_W-1:0] rem_q, dsh_q;
  logic [15:0]      quo_q;
  logic [3:0]       cnt_q;
  logic             ge;

  assign ge = (rem_q >= dsh_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= num_q;
      dsh_q <= NUM_W'(den_q) << (DIV_STEPS - 1);
      quo_q <= '0;
      cnt_q <= 4'(DIV_STEPS - 1);
    end else if (cmd_i.div_step) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[14:0], ge};
      dsh_q <= dsh_q >> 1;
      cnt_q <= cnt_q - 4'd1;
    end
  end

  // Output register.
  logic        out_valid_q, zero_q;
  logic [15:0] filt_q;
  logic [5:0]  orow_q, ocol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      zero_q <= (den_q == '0);
      filt_q <= (den_q == '0) ? 16'd0 : quo_q;
      orow_q <= row_q;
      ocol_q <= col_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign filtered_o    = filt_q;
  assign out_row_o     = orow_q;
  assign out_col_o     = ocol_q;
  assign zero_weight_o = zero_q;

  assign sts_o.pipe_busy = v1_q | v2_q | v3_q | v4_q;
  assign sts_o.div_last  = (cnt_q == 4'd0);
  assign sts_o.out_full  = out_valid_q;

endmodule

// ----- rtl/bfme_ctrl.sv -----
module bfme_ctrl #(
  parameter int RW = 2,
  parameter int DW = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           in_kind_i,
  input  logic [RW-1:0]        radius_i,
  input  bfme_pkg::sts_t       sts_i,
  output bfme_pkg::cmd_t       cmd_o,
  output logic signed [DW-1:0] di_o,
  output logic signed [DW-1:0] dj_o
);
  import bfme_pkg::*;

  state_e state_q, state_d;
  logic signed [DW-1:0] di_q, di_d, dj_q, dj_d, r_s;
  logic accept;

  assign r_s        = $signed(DW'(radius_i));
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign di_o       = (state_q == ST_TAPS) ? di_q : '0;
  assign dj_o       = (state_q == ST_TAPS) ? dj_q : '0;

  always_comb begin
    state_d = state_q;
    di_d    = di_q;
    dj_d    = dj_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_kind_i)
            KIND_PIXEL: cmd_o.wr_pixel = 1'b1;
            KIND_RANGE: cmd_o.wr_range = 1'b1;
            KIND_FILTER: begin
              cmd_o.latch_req = 1'b1;
              state_d         = ST_CENTRE;
            end
            default: ;
          endcase
        end
      end
      // Read of the centre pixel is in flight.
      ST_CENTRE: state_d = ST_CWAIT;
      ST_CWAIT: begin
        cmd_o.latch_centre = 1'b1;
        cmd_o.clear_acc    = 1'b1;
        di_d               = -r_s;
        dj_d               = -r_s;
        state_d            = ST_TAPS;
      end
      // One tap enters the pipeline per cycle, row by row.
      ST_TAPS: begin
        cmd_o.issue_tap = 1'b1;
        if (dj_q == r_s) begin
          dj_d = -r_s;
          if (di_q == r_s) begin
            state_d = ST_DRAIN;
          end else begin
            di_d = di_q + DW'(1);
          end
        end else begin
          dj_d = dj_q + DW'(1);
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!sts_i.out_full) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      di_q    <= '0;
      dj_q    <= '0;
    end else begin
      state_q <= state_d;
      di_q    <= di_d;
      dj_q    <= dj_d;
    end
  end

endmodule
